>>> src/lmrp_pkg.sv
package lmrp_pkg;

  localparam int EXTRA_COUNT_BITS = 24;

  localparam logic [7:0] HDR_LOAD = 8'h01;
  localparam logic [7:0] HDR_XFER = 8'h02;
  localparam logic [7:0] HDR_NAME = 8'h05;
  localparam logic [7:0] HDR_NOTE = 8'h1f;

  localparam logic [8:0] LEN_WRAP        = 9'd254;
  localparam logic [7:0] LEN_SMALL       = 8'd3;
  localparam logic [8:0] XF_LEN_REQUIRED = 9'd2;
  localparam logic [8:0] LEN_OFFSET      = 9'd2;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LOAD    = 3'd1,
    EV_XFER    = 3'd2,
    EV_NAME    = 3'd3,
    EV_COMMENT = 3'd4,
    EV_ERROR   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_XFERLEN = 2'd2
  } error_t;

  typedef enum logic [13:0] {
    PH_HEADER  = 14'b00000000000001,
    PH_LB_LEN  = 14'b00000000000010,
    PH_LB_LO   = 14'b00000000000100,
    PH_LB_HI   = 14'b00000000001000,
    PH_XF_LEN  = 14'b00000000010000,
    PH_XF_LO   = 14'b00000000100000,
    PH_XF_HI   = 14'b00000001000000,
    PH_NM_LEN  = 14'b00000010000000,
    PH_NM_TEXT = 14'b00000100000000,
    PH_CM_LEN  = 14'b00001000000000,
    PH_CM_TEXT = 14'b00010000000000,
    PH_SKIP    = 14'b00100000000000,
    PH_EXTRA   = 14'b01000000000000,
    PH_HALT    = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic                        keep_byte;
    logic [2:0]                  event_kind;
    logic [15:0]                 address_value;
    logic [8:0]                  block_length;
    logic [7:0]                  text_byte;
    logic                        text_last;
    logic [1:0]                  error_code;
    logic [EXTRA_COUNT_BITS-1:0] extra_count;
    logic                        file_done;
  } result_t;

endpackage

>>> src/load_module_record_parser.sv
// load module record parser: one file byte per request, one result per request
// an accepted request's result is registered in the output or skid register
// throughput: 1 request per cycle; a one-entry skid stage holds a result while
// the output is stalled, and the input stalls only while that stage is full
// reset (rst, synchronous): parser back to expecting a header byte, counts and
// error cleared, no result pending; the end-of-file byte resets the parser too
module load_module_record_parser import lmrp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  phase_t                      phase, phase_next;
  logic [8:0]                  skip_remaining, skip_remaining_next;
  logic [7:0]                  address_low, address_low_next;
  logic [7:0]                  text_remaining, text_remaining_next;
  logic [EXTRA_COUNT_BITS-1:0] extra_total, extra_total_next;
  logic [1:0]                  error_seen, error_seen_next;

  result_t res;
  result_t skid;
  logic    skid_valid;
  logic    accept;
  logic    take;
  logic [7:0] b;
  logic [7:0] text_dec;
  logic [8:0] skip_dec;

  assign accept     = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;
  assign item_stall = skid_valid;
  assign b          = item.data_byte;
  assign text_dec   = (text_remaining != 8'd0) ? text_remaining - 8'd1 : 8'd0;
  assign skip_dec   = (skip_remaining != 9'd0) ? skip_remaining - 9'd1 : 9'd0;

  always_comb begin
    phase_next          = phase;
    skip_remaining_next = skip_remaining;
    address_low_next    = address_low;
    text_remaining_next = text_remaining;
    extra_total_next    = extra_total;
    error_seen_next     = error_seen;
    res                 = '0;
    res.keep_byte       = !(phase == PH_EXTRA || phase == PH_HALT);
    res.event_kind      = EV_NONE;

    case (phase)
      PH_HEADER: begin
        if (b == HDR_LOAD) begin
          phase_next = PH_LB_LEN;
        end else if (b == HDR_XFER) begin
          phase_next = PH_XF_LEN;
        end else if (b == HDR_NAME) begin
          phase_next = PH_NM_LEN;
        end else if (b == HDR_NOTE) begin
          phase_next = PH_CM_LEN;
        end else begin
          res.event_kind  = EV_ERROR;
          error_seen_next = ERR_HEADER;
          phase_next      = PH_HALT;
        end
      end
      PH_LB_LEN: begin
        skip_remaining_next = (b < LEN_SMALL) ? {1'b0, b} + LEN_WRAP
                                              : {1'b0, b} - LEN_OFFSET;
        phase_next = PH_LB_LO;
      end
      PH_LB_LO: begin
        address_low_next = b;
        phase_next       = PH_LB_HI;
      end
      PH_LB_HI: begin
        res.event_kind    = EV_LOAD;
        res.address_value = {b, address_low};
        res.block_length  = skip_remaining;
        phase_next        = PH_SKIP;
      end
      PH_XF_LEN: begin
        skip_remaining_next = {1'b0, b};
        phase_next          = PH_XF_LO;
      end
      PH_XF_LO: begin
        address_low_next = b;
        phase_next       = PH_XF_HI;
      end
      PH_XF_HI: begin
        if (skip_remaining != XF_LEN_REQUIRED) begin
          res.event_kind  = EV_ERROR;
          error_seen_next = ERR_XFERLEN;
          phase_next      = PH_HALT;
        end else begin
          res.event_kind    = EV_XFER;
          res.address_value = {b, address_low};
          extra_total_next  = '0;
          phase_next        = PH_EXTRA;
        end
        skip_remaining_next = '0;
      end
      PH_NM_LEN, PH_CM_LEN: begin
        text_remaining_next = b;
        if (b == 8'd0) begin
          phase_next = PH_HEADER;
        end else begin
          phase_next = (phase == PH_NM_LEN) ? PH_NM_TEXT : PH_CM_TEXT;
        end
      end
      PH_NM_TEXT, PH_CM_TEXT: begin
        res.event_kind      = (phase == PH_NM_TEXT) ? EV_NAME : EV_COMMENT;
        res.text_byte       = b;
        text_remaining_next = text_dec;
        if (text_dec == 8'd0) begin
          res.text_last = 1'b1;
          phase_next    = PH_HEADER;
        end
      end
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 9'd0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_EXTRA: begin
        if (extra_total != '1) begin
          extra_total_next = extra_total + EXTRA_COUNT_BITS'(1);
        end
      end
      default: begin
      end
    endcase

    res.error_code  = error_seen_next;
    res.extra_count = extra_total_next;
    res.file_done   = item.end_of_file;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      skip_remaining <= '0;
      address_low    <= '0;
      text_remaining <= '0;
      extra_total    <= '0;
      error_seen     <= ERR_NONE;
    end else if (accept) begin
      if (item.end_of_file) begin
        phase          <= PH_HEADER;
        skip_remaining <= '0;
        address_low    <= '0;
        text_remaining <= '0;
        extra_total    <= '0;
        error_seen     <= ERR_NONE;
      end else begin
        phase          <= phase_next;
        skip_remaining <= skip_remaining_next;
        address_low    <= address_low_next;
        text_remaining <= text_remaining_next;
        extra_total    <= extra_total_next;
        error_seen     <= error_seen_next;
      end
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // payloads
  always_ff @(posedge clk) begin
    if (take || !result_valid) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= res;
      end
    end else if (accept) begin
      skid <= res;
    end
  end

endmodule
